@@ hdl/qrs_pkg.sv @@
// Shared types, constants and step functions of the quadratic root solver.
package qrs_pkg;

   localparam int CW         = 32;
   localparam int FB         = 16;
   localparam int THR_W      = 16;
   localparam int DW         = 2 * CW + 1;
   localparam int SQ_W       = CW + 1;
   localparam int SI_W       = 2 * SQ_W;
   localparam int SR_W       = SQ_W + 4;
   localparam int NB_W       = CW + 1;
   localparam int NUM_W      = CW + 3;
   localparam int NM_W       = NUM_W - 1;
   localparam int DM_W       = CW + 1;
   localparam int DR_W       = DM_W + 1;
   localparam int QW         = NM_W + FB;
   localparam int DIV_LAT    = QW + 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FP_W       = $clog2(FIFO_DEPTH);
   localparam int FC_W       = FP_W + 1;
   // clock edges from an input transfer to the edge of its result transfer
   localparam int RSP_LATENCY = SQ_W + QW + 6;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;
   localparam logic [1:0] CNT_INF  = 2'd3;

   localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] coef_a;
      logic signed [CW-1:0] coef_b;
      logic signed [CW-1:0] coef_c;
   } qrs_req_type;

   typedef struct packed {
      logic [1:0]           root_count;
      logic signed [CW-1:0] first_root;
      logic signed [CW-1:0] second_root;
      logic                 overflow;
   } qrs_rsp_type;

   typedef struct packed {
      logic [1:0]             count;
      logic [DW-1:0]          disc;
      logic signed [NB_W-1:0] numbase;
      logic signed [NB_W-1:0] den;
   } qrs_work_type;

   typedef struct packed {
      logic valid;
      logic almost_full;
   } qrs_fifo_stat_type;

   typedef struct packed {
      logic [SR_W-1:0] rem;
      logic [SQ_W-1:0] root;
      logic [SI_W-1:0] rad;
   } qrs_sq_type;

   typedef struct packed {
      logic [DR_W-1:0] rem;
      logic [QW-1:0]   dq;
      logic [DM_W-1:0] dvs;
      logic            neg;
   } qrs_div_type;

   function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] x);
      return x[CW-1] ? CW'(-x) : CW'(x);
   endfunction

   // one digit of the integer square root
   function automatic qrs_sq_type sq_step(input qrs_sq_type x);
      logic [SR_W-1:0] r;
      logic [SR_W-1:0] t;
      qrs_sq_type      y;
      r = {x.rem[SR_W-3:0], x.rad[SI_W-1 -: 2]};
      t = {2'b00, x.root, 2'b01};
      y.rad = {x.rad[SI_W-3:0], 2'b00};
      if (r >= t) begin
         y.rem  = r - t;
         y.root = {x.root[SQ_W-2:0], 1'b1};
      end else begin
         y.rem  = r;
         y.root = {x.root[SQ_W-2:0], 1'b0};
      end
      return y;
   endfunction

   // one quotient bit of restoring division
   function automatic qrs_div_type div_step(input qrs_div_type x);
      logic [DR_W-1:0] r;
      qrs_div_type     y;
      y = x;
      r = {x.rem[DR_W-2:0], x.dq[QW-1]};
      y.dq = {x.dq[QW-2:0], 1'b0};
      if (r >= DR_W'(x.dvs)) begin
         r = r - DR_W'(x.dvs);
         y.dq[0] = 1'b1;
      end
      y.rem = r;
      return y;
   endfunction

endpackage

@@ hdl/qrs_front.sv @@
// Front end: zero tests, products, discriminant and case selection.
module qrs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  qrs_pkg::qrs_req_type      req,
   input  logic [qrs_pkg::THR_W-1:0] thr,
   output logic                      push,
   output qrs_pkg::qrs_work_type     work
);
   import qrs_pkg::*;

   logic                 s1_v_ff;
   qrs_req_type          s1_ff;
   logic                 za_ff, zb_ff, zc_ff;
   logic                 s2_v_ff;
   logic signed [CW-1:0] a2_ff, b2c_ff, c2_ff;
   logic                 za2_ff, zb2_ff, zc2_ff;
   logic [2*CW-1:0]      bb_ff, ac_ff;
   logic [DW-1:0]        ac4, bbw, d, eps;
   logic                 dneg, dzero;
   qrs_work_type         work_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= req;
      za_ff  <= mag(req.coef_a) < CW'(thr);
      zb_ff  <= mag(req.coef_b) < CW'(thr);
      zc_ff  <= mag(req.coef_c) < CW'(thr);
      bb_ff  <= mag(s1_ff.coef_b) * mag(s1_ff.coef_b);
      ac_ff  <= mag(s1_ff.coef_a) * mag(s1_ff.coef_c);
      a2_ff  <= s1_ff.coef_a;
      b2c_ff <= s1_ff.coef_b;
      c2_ff  <= s1_ff.coef_c;
      za2_ff <= za_ff;
      zb2_ff <= zb_ff;
      zc2_ff <= zc_ff;
   end

   always_comb begin
      ac4   = DW'({ac_ff, 2'b00});
      bbw   = DW'(bb_ff);
      eps   = DW'(thr) << FB;
      dneg  = 1'b0;
      if (a2_ff[CW-1] ^ c2_ff[CW-1]) begin
         d = bbw + ac4;
      end else if (bbw >= ac4) begin
         d = bbw - ac4;
      end else begin
         d    = ac4 - bbw;
         dneg = 1'b1;
      end
      dzero = (d == '0);

      work_in.count   = CNT_NONE;
      work_in.disc    = d;
      work_in.numbase = '0;
      work_in.den     = {a2_ff, 1'b0};
      if (za2_ff && zb2_ff && zc2_ff) begin
         work_in.count = CNT_INF;
      end else if (!za2_ff) begin
         if (!dneg && !dzero) begin
            work_in.count   = CNT_TWO;
            work_in.numbase = -NB_W'(b2c_ff);
         end else if (dzero || d < eps) begin
            work_in.count   = CNT_ONE;
            work_in.numbase = -NB_W'(b2c_ff);
         end
      end else if (!zb2_ff) begin
         work_in.count = CNT_ONE;
         work_in.den   = NB_W'(b2c_ff);
         if (!zc2_ff) begin
            work_in.numbase = -NB_W'(c2_ff);
         end
      end
   end

   assign push = s2_v_ff;
   assign work = work_in;

endmodule

@@ hdl/qrs_fifo.sv @@
// Short queue between the front end and the back end.
module qrs_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  qrs_pkg::qrs_work_type      push_data,
   input  logic                       pop,
   output qrs_pkg::qrs_work_type      pop_data,
   output qrs_pkg::qrs_fifo_stat_type stat
);
   import qrs_pkg::*;

   qrs_work_type    mem_ff [FIFO_DEPTH];
   logic [FP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FC_W-1:0] count_ff, count_in;
   logic            do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + FC_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - FC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FP_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + FP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data         = mem_ff[rd_ptr_ff];
   assign stat.valid       = (count_ff != '0);
   assign stat.almost_full = (count_ff >= FC_W'(FIFO_DEPTH - 2));

endmodule

@@ hdl/qrs_div.sv @@
// Pipelined signed fixed-point divider with saturation, one quotient bit per stage.
module qrs_div (
   input  logic                             clock,
   input  logic signed [qrs_pkg::NUM_W-1:0] num,
   input  logic signed [qrs_pkg::NB_W-1:0]  den,
   output logic signed [qrs_pkg::CW-1:0]    root,
   output logic                             ovf
);
   import qrs_pkg::*;

   qrs_div_type          step_ff [QW+1];
   qrs_div_type          step_in [QW+1];
   logic [NM_W-1:0]      un;
   logic [DM_W-1:0]      ud;
   logic [QW-1:0]        lim, q, m;
   logic                 sat;
   logic signed [CW-1:0] root_ff;
   logic                 ovf_ff;

   assign un = num[NUM_W-1] ? NM_W'(-num) : NM_W'(num);
   assign ud = den[NB_W-1] ? DM_W'(-den) : DM_W'(den);

   always_comb begin
      step_in[0].rem = '0;
      step_in[0].dq  = {un, {FB{1'b0}}};
      // a zero numerator gives a zero quotient, also over a zero divisor
      step_in[0].dvs = (un == '0) ? DM_W'(1) : ud;
      step_in[0].neg = num[NUM_W-1] ^ den[NB_W-1];
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      assign step_in[k+1] = div_step(step_ff[k]);
   end

   for (genvar k = 0; k <= QW; k++) begin : g_reg
      always_ff @(posedge clock) begin
         step_ff[k] <= step_in[k];
      end
   end

   always_comb begin
      q   = step_ff[QW].dq;
      lim = step_ff[QW].neg ? (QW'(1) << (CW - 1)) : ((QW'(1) << (CW - 1)) - QW'(1));
      sat = q > lim;
      m   = sat ? lim : q;
   end

   always_ff @(posedge clock) begin
      root_ff <= step_ff[QW].neg ? CW'(-m) : CW'(m);
      ovf_ff  <= sat;
   end

   assign root = root_ff;
   assign ovf  = ovf_ff;

endmodule

@@ hdl/qrs_back.sv @@
// Back end: pipelined square root, numerators and the two root dividers.
module qrs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_valid,
   input  qrs_pkg::qrs_work_type work,
   output logic                  rsp_strobe,
   output qrs_pkg::qrs_rsp_type  rsp_data
);
   import qrs_pkg::*;

   qrs_sq_type              sq_ff [SQ_W];
   qrs_sq_type              sq_in [SQ_W];
   qrs_work_type            side_ff [SQ_W];
   logic [SQ_W-1:0]         sv_ff;
   logic                    nv_ff;
   logic [1:0]              ncnt_ff;
   logic signed [NUM_W-1:0] n1_ff, n2_ff, n1_in, n2_in;
   logic signed [NB_W-1:0]  den_ff;
   logic [DIV_LAT-1:0]      dv_ff;
   logic [1:0]              cnt_ff [DIV_LAT];
   logic [SQ_W-1:0]         s;
   logic                    two;
   logic signed [CW-1:0]    r1, r2;
   logic                    o1, o2;

   always_comb begin
      sq_in[0] = sq_step('{rem: '0, root: '0, rad: SI_W'(work.disc)});
   end

   for (genvar k = 1; k < SQ_W; k++) begin : g_sq
      assign sq_in[k] = sq_step(sq_ff[k-1]);
   end

   for (genvar k = 0; k < SQ_W; k++) begin : g_sqreg
      always_ff @(posedge clock) begin
         sq_ff[k]   <= sq_in[k];
         side_ff[k] <= (k == 0) ? work : side_ff[(k == 0) ? 0 : k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
         nv_ff <= 1'b0;
         dv_ff <= '0;
      end else begin
         sv_ff <= {sv_ff[SQ_W-2:0], work_valid};
         nv_ff <= sv_ff[SQ_W-1];
         dv_ff <= {dv_ff[DIV_LAT-2:0], nv_ff};
      end
   end

   always_comb begin
      s     = sq_ff[SQ_W-1].root;
      two   = (side_ff[SQ_W-1].count == CNT_TWO);
      n1_in = NUM_W'(side_ff[SQ_W-1].numbase) - (two ? NUM_W'(s) : '0);
      n2_in = two ? NUM_W'(side_ff[SQ_W-1].numbase) + NUM_W'(s) : '0;
   end

   always_ff @(posedge clock) begin
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      den_ff  <= side_ff[SQ_W-1].den;
      ncnt_ff <= side_ff[SQ_W-1].count;
   end

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_cnt
      always_ff @(posedge clock) begin
         cnt_ff[k] <= (k == 0) ? ncnt_ff : cnt_ff[(k == 0) ? 0 : k-1];
      end
   end

   qrs_div u_div_first (
      .clock (clock),
      .num   (n1_ff),
      .den   (den_ff),
      .root  (r1),
      .ovf   (o1)
   );

   qrs_div u_div_second (
      .clock (clock),
      .num   (n2_ff),
      .den   (den_ff),
      .root  (r2),
      .ovf   (o2)
   );

   assign rsp_strobe           = dv_ff[DIV_LAT-1];
   assign rsp_data.root_count  = cnt_ff[DIV_LAT-1];
   assign rsp_data.first_root  = r1;
   assign rsp_data.second_root = r2;
   assign rsp_data.overflow    = o1 | o2;

endmodule

@@ hdl/quadratic_root_solver_unit.sv @@
// Top level of the quadratic root solver.
//
// Usage: drive req_data with coefficients a, b, c (signed Q16.16) and raise
// start; the transfer happens at a clock edge where start is high and busy
// is low. One result comes back per transfer on rsp_data, shown for exactly
// one cycle while rsp_strobe is high. A new item may enter every cycle
// while busy is low. The back end holds the 33-step square root pipeline
// and the two 50-step dividers, one bit per stage; a 4-entry queue sits
// between front and back. busy rises only when that queue nears full, which
// a steady stream with a result side that never stalls does not reach.
// csr_wr_en/csr_wr_data write the zero threshold (raw Q units); write it
// only while no item is in flight.
// Reset (synchronous) empties the pipeline and queue and sets the threshold
// to 1. The receiver cannot stall: each result must be taken when strobed.
module quadratic_root_solver_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  qrs_pkg::qrs_req_type      req_data,
   output logic                      rsp_strobe,
   output qrs_pkg::qrs_rsp_type      rsp_data,
   input  logic                      csr_wr_en,
   input  logic [qrs_pkg::THR_W-1:0] csr_wr_data
);
   import qrs_pkg::*;

   logic [THR_W-1:0]  thr_ff;
   logic              accept, push;
   qrs_work_type      work, head;
   qrs_fifo_stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   assign busy   = stat.almost_full;
   assign accept = start && !busy;

   qrs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .thr    (thr_ff),
      .push   (push),
      .work   (work)
   );

   qrs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (work),
      .pop       (stat.valid),
      .pop_data  (head),
      .stat      (stat)
   );

   qrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (stat.valid),
      .work       (head),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ hdl/qrs_checker.sv @@
// Port-level assertions for the quadratic root solver, bound to the top level.
module qrs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_strobe,
   input qrs_pkg::qrs_rsp_type rsp_data
);
   import qrs_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without matching input transfer");

   a_no_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.root_count == CNT_NONE || rsp_data.root_count == CNT_INF)
      |-> rsp_data.first_root == '0 && rsp_data.second_root == '0 && !rsp_data.overflow)
      else $error("root value without a root");

   a_second: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.root_count != CNT_TWO |-> rsp_data.second_root == '0)
      else $error("second root set without two roots");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.overflow |->
      rsp_data.first_root == SAT_MAX || rsp_data.first_root == SAT_MIN ||
      rsp_data.second_root == SAT_MAX || rsp_data.second_root == SAT_MIN)
      else $error("overflow without a saturated root");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);

@@ tb/quadratic_root_solver_unit_tb.sv @@
// Testbench for the quadratic root solver: random and directed coefficient sets checked against a predictor.
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
   import qrs_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   qrs_req_type       req_data = '0;
   logic              rsp_strobe;
   qrs_rsp_type       rsp_data;
   logic              csr_wr_en = 1'b0;
   logic [THR_W-1:0]  csr_wr_data = '0;

   qrs_req_type       coef_queue[$];
   qrs_rsp_type       root_queue[$];
   logic [THR_W-1:0]  thr_now = THR_RESET;
   int                mismatches = 0;
   int                gap_left = 0;
   int                burst_left = 8;

   quadratic_root_solver_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CW-1:0] scaled_quotient(input longint num, input longint den,
                                                     inout bit ovf);
      logic [127:0] un;
      logic [127:0] ud;
      logic [127:0] q;
      logic [127:0] lim;
      bit           neg;
      un  = 128'(num < 0 ? -num : num);
      ud  = 128'(den < 0 ? -den : den);
      neg = (num < 0) != (den < 0);
      if (un == 0) return '0;
      if (ud == 0) begin
         ovf = 1'b1;
         return num < 0 ? SAT_MIN : SAT_MAX;
      end
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      q = (un << FB) / ud;
      if (q > lim) begin
         ovf = 1'b1;
         q = lim;
      end
      return neg ? CW'(-q) : CW'(q);
   endfunction

   function automatic longint floor_sqrt(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] t;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (128'd1 << i);
         if (t * t <= v) r = t;
      end
      return longint'(r[63:0]);
   endfunction

   function automatic qrs_rsp_type solve_roots(input qrs_req_type x, input logic [THR_W-1:0] thr);
      longint       a, b, c, s;
      logic [127:0] ma, mb, mc, b2, ac, d, eps;
      bit           za, zb, zc, dneg, ovf;
      qrs_rsp_type  y;
      a = longint'(x.coef_a);
      b = longint'(x.coef_b);
      c = longint'(x.coef_c);
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      mc = 128'(c < 0 ? -c : c);
      za = ma < thr;
      zb = mb < thr;
      zc = mc < thr;
      y = '0;
      ovf = 1'b0;
      if (za && zb && zc) begin
         y.root_count = CNT_INF;
      end else if (!za) begin
         b2 = mb * mb;
         ac = (ma * mc) << 2;
         eps = 128'(thr) << FB;
         dneg = 1'b0;
         if ((a < 0) != (c < 0)) d = b2 + ac;
         else if (b2 >= ac) d = b2 - ac;
         else begin
            d = ac - b2;
            dneg = 1'b1;
         end
         if (!dneg && d != 0) begin
            s = floor_sqrt(d);
            y.root_count  = CNT_TWO;
            y.first_root  = scaled_quotient(-b - s, 2 * a, ovf);
            y.second_root = scaled_quotient(-b + s, 2 * a, ovf);
         end else if (d == 0 || d < eps) begin
            y.root_count = CNT_ONE;
            y.first_root = scaled_quotient(-b, 2 * a, ovf);
         end else begin
            y.root_count = CNT_NONE;
         end
      end else if (!zb) begin
         y.root_count = CNT_ONE;
         if (!zc) y.first_root = scaled_quotient(-c, b, ovf);
      end else begin
         y.root_count = CNT_NONE;
      end
      y.overflow = ovf;
      return y;
   endfunction

   function automatic logic [CW-1:0] pick_coef(input logic [THR_W-1:0] thr);
      logic [CW-1:0] v;
      case ($urandom_range(0, 6))
         0: v = $urandom;
         1: v = CW'($urandom_range(0, 2 * thr + 2)) - CW'(thr + 1);
         2: v = $urandom_range(0, 1) ? SAT_MIN : SAT_MAX;
         3: v = $urandom >>> $urandom_range(0, 31);
         4: v = '0;
         5: v = CW'(int'($urandom_range(0, 64)) - 32) << FB;
         default: v = $signed($urandom) >>> $urandom_range(8, 28);
      endcase
      return v;
   endfunction

   task automatic add_item(input int a, input int b, input int c);
      qrs_req_type x;
      x.coef_a = a;
      x.coef_b = b;
      x.coef_c = c;
      coef_queue.push_back(x);
   endtask

   task automatic load_phase(input logic [THR_W-1:0] thr, input int count);
      int r, s;
      add_item(0, 0, 0);
      add_item(0, 0, 5 << 16);
      add_item(0, 2 << 16, 4 << 16);
      add_item(0, 3 << 16, 0);
      add_item(1 << 16, 0, -(4 << 16));
      add_item(1 << 16, 2 << 16, 1 << 16);
      add_item(-(1 << 16), 4 << 16, -(4 << 16));
      add_item(1 << 16, 0, 4 << 16);
      add_item(1, 0, 1);
      add_item(1, 1, 0);
      add_item(int'(SAT_MIN), int'(SAT_MIN), int'(SAT_MIN));
      add_item(int'(SAT_MAX), int'(SAT_MAX), int'(SAT_MAX));
      add_item(int'(SAT_MIN), int'(SAT_MAX), int'(SAT_MIN));
      add_item(1, int'(SAT_MAX), 1);
      add_item(1, 0, int'(SAT_MIN));
      add_item(int'(SAT_MAX), int'(SAT_MIN), 0);
      add_item(0, 1, int'(SAT_MIN));
      add_item(-1, -1, -1);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            r = $urandom_range(1, 300) * ($urandom_range(0, 1) ? 1 : -1);
            s = int'($urandom_range(0, 400)) - 200;
            add_item(r, 2 * r * s, r * s * s);
         end else begin
            add_item(pick_coef(thr), pick_coef(thr), pick_coef(thr));
         end
      end
   endtask

   // transfers, configuration mirror and result check
   always @(posedge clock) begin
      qrs_rsp_type want;
      if (!reset) begin
         if (csr_wr_en) thr_now = csr_wr_data;
         if (start && !busy) begin
            root_queue.push_back(solve_roots(req_data, thr_now));
            void'(coef_queue.pop_front());
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
            end
         end
         if (rsp_strobe) begin
            if (root_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = root_queue.pop_front();
               if (rsp_data.root_count !== want.root_count ||
                   rsp_data.first_root !== want.first_root ||
                   rsp_data.second_root !== want.second_root ||
                   rsp_data.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || coef_queue.size() == 0) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         start <= 1'b0;
      end else begin
         start <= 1'b1;
         req_data <= coef_queue[0];
      end
   end

   initial begin
      logic [THR_W-1:0] thr_list[6];
      thr_list = '{THR_RESET, 16'hffff, 16'h0000, 16'h5555, 16'haaaa, 16'h0000};
      thr_list[5] = $urandom_range(2, 4000);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            wait (coef_queue.size() == 0 && root_queue.size() == 0);
            repeat (RSP_LATENCY + 4) @(posedge clock);
            @(negedge clock);
            csr_wr_en <= 1'b1;
            csr_wr_data <= thr_list[p];
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end
         load_phase(thr_list[p], 175);
      end
      wait (coef_queue.size() == 0 && root_queue.size() == 0);
      repeat (RSP_LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && root_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
